>>> hdl/yrgb_pkg.sv
`timescale 1ns / 1ps

package yrgb_pkg;

    // Fixed-point format of the channel sums
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 27;

    localparam logic signed [SUM_W-1:0] COEF_LUMA    = 27'sd76309;
    localparam logic signed [SUM_W-1:0] COEF_RED_V   = 27'sd104597;
    localparam logic signed [SUM_W-1:0] COEF_BLUE_U  = 27'sd132201;
    localparam logic signed [SUM_W-1:0] COEF_GREEN_U = 27'sd25675;
    localparam logic signed [SUM_W-1:0] COEF_GREEN_V = 27'sd53279;
    localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 27'sd16;
    localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 27'sd128;

    // Pixel order inside a block
    localparam logic [1:0] PIX_TOP_LEFT     = 2'd0;
    localparam logic [1:0] PIX_BOTTOM_LEFT  = 2'd1;
    localparam logic [1:0] PIX_TOP_RIGHT    = 2'd2;
    localparam logic [1:0] PIX_BOTTOM_RIGHT = 2'd3;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lower_row;
        logic       right_column;
        logic       last_of_block;
    } t_out_word;

    typedef struct packed {
        logic lower_row;
        logic right_column;
        logic last_of_block;
    } t_pix_tag;

    // Floor shift by FRAC_BITS, then clamp to 0..255
    function automatic logic [7:0] sat_channel(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
            res = 8'hFF;
        end else begin
            res = sum[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

>>> hdl/yuv420_block_to_rgb24_top.sv
`timescale 1ns / 1ps

// YUV 4:2:0 block to RGB24 converter, BT.601 coefficients, 16-bit fraction.
//
// Input channel (i_valid / o_ready / i_data): one word per 2x2 block, four
// luma bytes plus the shared u (chroma_blue) and v (chroma_red) bytes.
// Output channel (o_valid / i_ready / o_data): four words per block, one
// pixel each, in the order top-left, bottom-left, top-right, bottom-right,
// tagged with row, column and a last-of-block flag.
//
// Throughput: set by the single-pixel output channel; the block register
// emits one pixel per cycle into the pipe while stage 1 can load.
// Path: a pixel passes the issue, multiply, sum and clamp registers in
// that order before it is shown.
// A new block is accepted in the same cycle as the last pixel of the
// current one is issued, so blocks follow without gaps.
//
// Reset (synchronous, active low) empties the block register and all
// pipeline stages; no word is pending afterwards.
// When the receiver holds i_ready low, the output word is held and the
// stall ripples back stage by stage; nothing is lost or repeated.
module yuv420_block_to_rgb24_top
    import yrgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    // block register
    logic       r_blk_valid;
    t_in_word   r_blk;
    logic [1:0] r_idx;

    // stage 1: products
    logic                    r_s1_valid;
    t_pix_tag                r_s1_tag;
    logic signed [SUM_W-1:0] r_s1_luma;
    logic signed [SUM_W-1:0] r_s1_red;
    logic signed [SUM_W-1:0] r_s1_gu;
    logic signed [SUM_W-1:0] r_s1_gv;
    logic signed [SUM_W-1:0] r_s1_blue;

    // stage 2: channel sums
    logic                    r_s2_valid;
    t_pix_tag                r_s2_tag;
    logic signed [SUM_W-1:0] r_s2_red;
    logic signed [SUM_W-1:0] r_s2_green;
    logic signed [SUM_W-1:0] r_s2_blue;

    // stage 3: output register
    logic      r_out_valid;
    t_out_word r_out;

    logic s1_ready, s2_ready, s3_ready;
    logic issue, in_acc;

    logic [7:0]              n_luma;
    logic signed [SUM_W-1:0] n_luma_d, n_u_d, n_v_d;
    t_pix_tag                n_tag;

    // each stage loads when empty or when its contents move on
    assign s3_ready = !r_out_valid || i_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign issue   = r_blk_valid && s1_ready;
    assign o_ready = !r_blk_valid || (issue && (r_idx == PIX_BOTTOM_RIGHT));
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        case (r_idx)
            PIX_TOP_LEFT:     n_luma = r_blk.luma_top_left;
            PIX_BOTTOM_LEFT:  n_luma = r_blk.luma_bottom_left;
            PIX_TOP_RIGHT:    n_luma = r_blk.luma_top_right;
            PIX_BOTTOM_RIGHT: n_luma = r_blk.luma_bottom_right;
            default:          n_luma = r_blk.luma_top_left;
        endcase
        n_tag.lower_row     = r_idx[0];
        n_tag.right_column  = r_idx[1];
        n_tag.last_of_block = (r_idx == PIX_BOTTOM_RIGHT);
    end

    assign n_luma_d = $signed({{(SUM_W-8){1'b0}}, n_luma}) - LUMA_OFFSET;
    assign n_u_d    = $signed({{(SUM_W-8){1'b0}}, r_blk.chroma_blue}) - CHROMA_OFFSET;
    assign n_v_d    = $signed({{(SUM_W-8){1'b0}}, r_blk.chroma_red}) - CHROMA_OFFSET;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_idx       <= PIX_TOP_LEFT;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_blk_valid <= 1'b1;
            end else if (issue && (r_idx == PIX_BOTTOM_RIGHT)) begin
                r_blk_valid <= 1'b0;
            end
            if (issue) begin
                r_idx <= r_idx + 2'd1;
            end
            if (s1_ready) begin
                r_s1_valid <= issue;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk <= i_data;
        end
        if (issue) begin
            r_s1_tag  <= n_tag;
            r_s1_luma <= n_luma_d * COEF_LUMA;
            r_s1_red  <= n_v_d * COEF_RED_V;
            r_s1_gu   <= n_u_d * COEF_GREEN_U;
            r_s1_gv   <= n_v_d * COEF_GREEN_V;
            r_s1_blue <= n_u_d * COEF_BLUE_U;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_tag   <= r_s1_tag;
            r_s2_red   <= r_s1_luma + r_s1_red;
            r_s2_green <= r_s1_luma - r_s1_gu - r_s1_gv;
            r_s2_blue  <= r_s1_luma + r_s1_blue;
        end
        if (s3_ready && r_s2_valid) begin
            r_out.red           <= sat_channel(r_s2_red);
            r_out.green         <= sat_channel(r_s2_green);
            r_out.blue          <= sat_channel(r_s2_blue);
            r_out.lower_row     <= r_s2_tag.lower_row;
            r_out.right_column  <= r_s2_tag.right_column;
            r_out.last_of_block <= r_s2_tag.last_of_block;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hdl/yrgb_checker.sv
`timescale 1ns / 1ps

module yrgb_checker
    import yrgb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // offered input word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("input word changed while waiting");

    // reset leaves nothing pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // last flag only on the bottom-right pixel
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_of_block == (o_data.lower_row && o_data.right_column)))
        else $error("last_of_block does not match pixel position");

    // after a top-left pixel is taken, the next shown pixel of the block is
    // the bottom-left one whenever it follows straight on
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.lower_row && !o_data.right_column
        |=> !o_valid || (o_data.lower_row && !o_data.right_column))
        else $error("pixel order broken after top-left");

endmodule

bind yuv420_block_to_rgb24_top yrgb_checker u_yrgb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the 4:2:0 block to RGB24 converter.
// One word in carries a whole 2x2 block; four pixel words come out.
// Each accepted block is run through a local BT.601 fixed-point model and
// the four pixels it should yield are queued.  Every pixel word accepted on
// the output side is compared with the oldest queued pixel.
module testbench;
    import yrgb_pkg::*;

    // Pixel scoreboard: turns an accepted block into its four pixels and
    // checks the pixel words as they leave the converter.
    class pixel_scoreboard;
        t_out_word pixels_due[$];
        int        mismatches;
        int        pixels_checked;
        int        blocks_seen;

        function new();
            mismatches     = 0;
            pixels_checked = 0;
            blocks_seen    = 0;
        endfunction

        // Floor shift of the 16-bit fraction, then clamp to a byte
        function logic [7:0] clamp_to_byte(longint sum);
            longint whole;
            whole = sum >>> 16;
            if (whole < 0) begin
                return 8'd0;
            end
            if (whole > 255) begin
                return 8'd255;
            end
            return whole[7:0];
        endfunction

        function void note_block(t_in_word blk);
            longint    u;
            longint    v;
            longint    luma;
            longint    red_part;
            longint    green_part;
            longint    blue_part;
            logic [1:0] pix;
            t_out_word px;
            u          = longint'(blk.chroma_blue);
            v          = longint'(blk.chroma_red);
            u          = u - 128;
            v          = v - 128;
            red_part   = v * 104597;
            green_part = u * 25675 + v * 53279;
            blue_part  = u * 132201;
            for (int k = 0; k < 4; k++) begin
                pix = k[1:0];
                case (pix)
                    PIX_TOP_LEFT: begin
                        luma = longint'(blk.luma_top_left);
                        px.lower_row = 1'b0; px.right_column = 1'b0;
                    end
                    PIX_BOTTOM_LEFT: begin
                        luma = longint'(blk.luma_bottom_left);
                        px.lower_row = 1'b1; px.right_column = 1'b0;
                    end
                    PIX_TOP_RIGHT: begin
                        luma = longint'(blk.luma_top_right);
                        px.lower_row = 1'b0; px.right_column = 1'b1;
                    end
                    default: begin
                        luma = longint'(blk.luma_bottom_right);
                        px.lower_row = 1'b1; px.right_column = 1'b1;
                    end
                endcase
                luma = (luma - 16) * 76309;
                px.red           = clamp_to_byte(luma + red_part);
                px.green         = clamp_to_byte(luma - green_part);
                px.blue          = clamp_to_byte(luma + blue_part);
                px.last_of_block = (pix == PIX_BOTTOM_RIGHT);
                pixels_due.push_back(px);
            end
            blocks_seen++;
        endfunction

        function void check_pixel(t_out_word got);
            t_out_word want;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected pixel word r=%0d g=%0d b=%0d tag=%b%b%b",
                             $realtime, got.red, got.green, got.blue,
                             got.lower_row, got.right_column, got.last_of_block);
                end
                return;
            end
            want = pixels_due.pop_front();
            pixels_checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.lower_row !== want.lower_row ||
                got.right_column !== want.right_column ||
                got.last_of_block !== want.last_of_block) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: pixel %0d wrong: want r=%0d g=%0d b=%0d tag=%b%b%b",
                           $realtime, pixels_checked,
                           want.red, want.green, want.blue,
                           want.lower_row, want.right_column, want.last_of_block);
                    $display(", got r=%0d g=%0d b=%0d tag=%b%b%b",
                             got.red, got.green, got.blue,
                             got.lower_row, got.right_column, got.last_of_block);
                end
            end
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    localparam int N_RANDOM   = 160;
    localparam int N_CALM     = 40;      // last blocks run with no idling
    localparam int SETTLE_CYC = 12;      // extra wait once no pixel is owed any more

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    // Set for the closing stretch: neither side idles any more
    bit calm;
    int stall_left;
    int pauses_to_drain;

    pixel_scoreboard sb;

    yuv420_block_to_rgb24_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("Timed out waiting for the converter");
        $display("RESULT: ERROR");
        $finish;
    end

    // Output side: every pixel word taken is checked against the queue
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_pixel(o_data);
        end
    end

    // Receiver back-pressure: random stall bursts, none once calm is set.
    // One assignment per falling edge only.
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_word mk_block(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
                                          logic [7:0] br, logic [7:0] u, logic [7:0] v);
        t_in_word w;
        w.luma_top_left     = tl;
        w.luma_top_right    = tr;
        w.luma_bottom_left  = bl;
        w.luma_bottom_right = br;
        w.chroma_blue       = u;
        w.chroma_red        = v;
        return w;
    endfunction

    // Mostly uniform bytes, with the clamp corners and the offsets mixed in
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = 8'd0;
            1:       b = 8'd255;
            2:       b = 8'd16;
            3:       b = 8'd128;
            4:       b = 8'd235;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Offer one block word and hold it until the converter takes it
    task automatic send_block(t_in_word blk);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= blk;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_block(blk);
    endtask

    // Sender idles for a random burst now and then
    task automatic maybe_idle();
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every pixel already owed has come out
    task automatic drain_pixels();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        pauses_to_drain++;
    endtask

    initial begin
        t_in_word directed[$];
        sb              = new();
        calm            = 1'b0;
        pauses_to_drain = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data          = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed blocks: corners of every byte, neutral grey, all chroma
        // extremes, distinct lumas to pin the pixel order, floor rounding of
        // small negative sums, and saturation at both ends.
        directed.push_back(mk_block(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
        directed.push_back(mk_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        directed.push_back(mk_block(8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128));
        directed.push_back(mk_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
        directed.push_back(mk_block(8'd10,  8'd80,  8'd160, 8'd240, 8'd128, 8'd128));
        directed.push_back(mk_block(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd0));
        directed.push_back(mk_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255));
        directed.push_back(mk_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0));
        directed.push_back(mk_block(8'd16,  8'd100, 8'd200, 8'd235, 8'd0,   8'd128));
        directed.push_back(mk_block(8'd255, 8'd17,  8'd15,  8'd200, 8'd255, 8'd128));
        directed.push_back(mk_block(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA));
        directed.push_back(mk_block(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55));
        directed.push_back(mk_block(8'd17,  8'd17,  8'd17,  8'd17,  8'd129, 8'd127));
        directed.push_back(mk_block(8'd16,  8'd16,  8'd16,  8'd16,  8'd129, 8'd128));
        directed.push_back(mk_block(8'd81,  8'd81,  8'd81,  8'd81,  8'd128, 8'd128));
        directed.push_back(mk_block(8'd15,  8'd0,   8'd1,   8'd14,  8'd255, 8'd255));
        directed.push_back(mk_block(8'd240, 8'd250, 8'd245, 8'd255, 8'd0,   8'd255));
        directed.push_back(mk_block(8'd200, 8'd60,  8'd120, 8'd30,  8'd127, 8'd129));

        foreach (directed[i]) begin
            send_block(directed[i]);
            maybe_idle();
        end
        drain_pixels();

        // Random blocks; a drain pause now and then, the tail with no idling
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) begin
                calm = 1'b1;
            end
            if (n == 60 || n == 110) begin
                drain_pixels();
            end
            send_block(mk_block(pick_byte(), pick_byte(), pick_byte(),
                                pick_byte(), pick_byte(), pick_byte()));
            maybe_idle();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Converted %0d blocks, %0d pixel words checked, %0d mismatches.",
                 sb.blocks_seen, sb.pixels_checked, sb.mismatches);
        $display("Included clamp corners, floor rounding, %0d drain pauses and stall bursts.",
                 pauses_to_drain);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> yuv420_block_to_rgb24_top.f
hdl/yrgb_pkg.sv
hdl/yuv420_block_to_rgb24_top.sv
hdl/yrgb_checker.sv
bench/testbench.sv
